// ===== rtl/core/lfobp_pkg.sv =====
// Package with the shared constants and types of the object box frame parser.
package lfobp_pkg;

  localparam int unsigned POS_W = 5;

  localparam logic [7:0] HDR_BYTE = 8'hCC;
  localparam logic [7:0] TRL_BYTE = 8'hEE;
  localparam logic [POS_W-1:0] FRAME_LAST = 5'd17;
  localparam logic [POS_W-1:0] FIELD_FIRST = 5'd9;
  localparam logic [15:0] NO_OBJECT = 16'hFFFF;

  typedef struct packed {
    logic [15:0] box_height;
    logic [15:0] box_width;
    logic [15:0] box_y;
    logic [15:0] box_x;
    logic box_seen;
  } box_t;

  typedef struct packed {
    logic result;
    logic [POS_W-1:0] pos;
  } frame_stat_t;

endpackage

// ===== rtl/core/lfobp_frame.sv =====
// Frame position tracking, field byte capture and trailer check.
module lfobp_frame
  import lfobp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output frame_stat_t stat,
  output box_t        box
);

  logic [POS_W-1:0] frame_position;
  logic [POS_W-1:0] frame_position_next;
  logic [7:0]       field_bytes [8];
  logic [2:0]       field_idx;
  logic             in_fields;

  assign field_idx = 3'(frame_position - FIELD_FIRST);
  assign in_fields = (frame_position >= FIELD_FIRST) && (frame_position < FRAME_LAST);

  always_comb begin
    frame_position_next = frame_position;
    if (frame_position == '0) begin
      if (rx_byte == HDR_BYTE) begin
        frame_position_next = POS_W'(1);
      end
    end else if (frame_position < FRAME_LAST) begin
      frame_position_next = frame_position + POS_W'(1);
    end else begin
      frame_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
    end else if (step) begin
      frame_position <= frame_position_next;
    end
  end

  // Field bytes need no reset: each one is written before the trailer reads it.
  always_ff @(posedge clk) begin
    if (step && in_fields) begin
      field_bytes[field_idx] <= rx_byte;
    end
  end

  assign stat.pos    = frame_position;
  assign stat.result = step && (frame_position == FRAME_LAST) && (rx_byte == TRL_BYTE);

  assign box.box_x      = {field_bytes[1], field_bytes[0]};
  assign box.box_y      = {field_bytes[3], field_bytes[2]};
  assign box.box_width  = {field_bytes[5], field_bytes[4]};
  assign box.box_height = {field_bytes[7], field_bytes[6]};
  assign box.box_seen   = ({field_bytes[1], field_bytes[0]} != NO_OBJECT);

endmodule

// ===== rtl/core/lfobp_out.sv =====
// Result register that holds one finished box until the receiver takes it.
module lfobp_out
  import lfobp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  box_t box_in,
  input  logic take,
  output logic free,
  output logic valid,
  output box_t box_out
);

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      box_out <= box_in;
    end
  end

endmodule

// ===== rtl/core/long_frame_object_box_parser.sv =====
// Top level of the object box frame parser: input register, frame logic, result register.
//
// The slave channel (s_tvalid, s_tready, s_tdata) carries one received byte per item.
// Bytes are searched for the 0xCC header; after it, 17 more bytes complete an 18-byte
// frame. Bytes 9 to 16 hold x, y, width and height as little-endian 16-bit values, and
// byte 17 must be the 0xEE trailer. A good frame yields one item on the master channel
// (m_tvalid, m_tready, m_tdata, m_tuser); a bad trailer drops the frame silently.
// Either way the parser looks for a new header on the next byte.
// A trailer byte is first held in the input register, and its frame step loads the result
// register, which raises m_tvalid. Throughput: one byte per cycle while no result waits
// on a stalled receiver, set by the frame step between the input and result registers.
// Reset clears the frame position and both valid flags; any partial frame is lost.
// When the receiver stalls with a result waiting, the frame step halts for every byte:
// the byte in the input register waits there, and s_tready drops since that register
// cannot move on. Bytes flow again in the cycle the receiver takes the result.
module long_frame_object_box_parser
  import lfobp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] box_x, [31:16] box_y, [47:32] box_width,
                                 // [63:48] box_height
  output logic        m_tuser    // [0] box_seen
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        step;
  logic        out_free;
  frame_stat_t stat;
  box_t        frame_box;
  box_t        out_box;

  // The frame step only runs when the result register can take whatever it produces.
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  lfobp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .stat    (stat),
    .box     (frame_box)
  );

  lfobp_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (stat.result),
    .box_in  (frame_box),
    .take    (m_tready),
    .free    (out_free),
    .valid   (m_tvalid),
    .box_out (out_box)
  );

  assign m_tdata = {out_box.box_height, out_box.box_width, out_box.box_y, out_box.box_x};
  assign m_tuser = out_box.box_seen;

  // The frame position never runs past the trailer slot.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    stat.pos <= FRAME_LAST)
    else $error("frame position out of range");

  // A new result only appears after a trailer byte was stepped.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(step && in_byte == TRL_BYTE && stat.pos == FRAME_LAST))
    else $error("result without a trailer");

  // A byte held in the input register while the output is blocked is kept.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> (in_valid && $stable(in_byte)))
    else $error("stalled byte lost");

  // The box seen flag always matches the sentinel test on x.
  a_seen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[15:0] != NO_OBJECT)))
    else $error("box seen flag mismatch");

endmodule

// ===== sim/box_report_checker.sv =====
// Checker that predicts object box reports from accepted bytes and compares the results.
module box_report_checker
  import lfobp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [POS_W-1:0] frame_pos;
  logic [7:0]       held_fields[8];
  box_t             predicted_boxes[$];

  initial begin
    fail_count = 0;
    checked = 0;
    frame_pos = '0;
  end

  assign pending = predicted_boxes.size();

  // Advance the frame position by one byte and return a box when a good trailer closes it.
  function automatic bit parse_byte(input logic [7:0] b, output box_t box);
    logic [2:0] slot;
    parse_byte = 1'b0;
    box = '0;
    if (frame_pos == '0) begin
      if (b == HDR_BYTE) frame_pos = 5'd1;
    end else if (frame_pos < FRAME_LAST) begin
      if (frame_pos >= FIELD_FIRST) begin
        slot = 3'(frame_pos - FIELD_FIRST);
        held_fields[slot] = b;
      end
      frame_pos = frame_pos + 5'd1;
    end else begin
      frame_pos = '0;
      if (b == TRL_BYTE) begin
        box.box_x      = {held_fields[1], held_fields[0]};
        box.box_y      = {held_fields[3], held_fields[2]};
        box.box_width  = {held_fields[5], held_fields[4]};
        box.box_height = {held_fields[7], held_fields[6]};
        box.box_seen   = (box.box_x != NO_OBJECT);
        parse_byte = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    box_t want;
    box_t made;
    if (rst) begin
      frame_pos = '0;
      predicted_boxes.delete();
    end else begin
      // Results are compared before the byte of this edge is parsed; a byte never
      // produces its result at the edge it is accepted.
      if (m_tvalid && m_tready) begin
        if (predicted_boxes.size() == 0) begin
          $error("unexpected box report: x=%h y=%h w=%h h=%h seen=%b",
                 m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48], m_tuser);
          fail_count++;
        end else begin
          want = predicted_boxes.pop_front();
          checked++;
          if (m_tdata[15:0] !== want.box_x) begin
            $error("box_x mismatch: expected %h, got %h", want.box_x, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[31:16] !== want.box_y) begin
            $error("box_y mismatch: expected %h, got %h", want.box_y, m_tdata[31:16]);
            fail_count++;
          end
          if (m_tdata[47:32] !== want.box_width) begin
            $error("box_width mismatch: expected %h, got %h", want.box_width, m_tdata[47:32]);
            fail_count++;
          end
          if (m_tdata[63:48] !== want.box_height) begin
            $error("box_height mismatch: expected %h, got %h",
                   want.box_height, m_tdata[63:48]);
            fail_count++;
          end
          if (m_tuser !== want.box_seen) begin
            $error("box_seen mismatch: expected %b, got %b", want.box_seen, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (parse_byte(s_tdata, made)) predicted_boxes.push_back(made);
      end
    end
  end

endmodule

// ===== sim/tb_long_frame_object_box_parser.sv =====
// Testbench top for the object box frame parser: clock, reset, byte stimulus and verdict.
module tb_long_frame_object_box_parser
  import lfobp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Limit for the watchdog, which counts cycles in which neither channel moves an item.
  localparam int IDLE_LIMIT = 2000;
  localparam int BYTE_TARGET = 850;

  // Receiver behavior; each mode holds for a random stretch of cycles.
  typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  int fail_count;
  int pending;
  int checked;
  int idle_cycles = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int burst_left = 0;

  rx_mode_e   rx_mode = RX_ALWAYS;
  int         mode_left = 0;
  logic [3:0] rx_phase = '0;

  always #6 clk = ~clk;

  long_frame_object_box_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  box_report_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // The receiver switches between always ready, coin-flip stalls, mostly stalled and a
  // fixed on/off pattern, so that back pressure lands on every phase of a frame.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 4'd1;
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   m_tready <= 1'b1;
      RX_HALF:     m_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
      default:     m_tready <= rx_phase[3];
    endcase
  end

  // Watchdog: any accepted item on either side resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles.", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte and hold it until the parser takes it. The sender works in bursts;
  // when a burst runs out it drops valid and sits idle for a random gap.
  task automatic send_byte(input logic [7:0] b);
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Some bursts are long enough to cover several frames with no gap at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(0, 20);
    end
  endtask

  // Padding bytes lean toward the header and trailer values and the extremes.
  function automatic logic [7:0] pad_byte();
    case ($urandom_range(0, 7))
      0:       return HDR_BYTE;
      1:       return TRL_BYTE;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Field values often hit the no-object sentinel, zero and the header and trailer bytes.
  function automatic logic [15:0] field_value();
    case ($urandom_range(0, 5))
      0:       return NO_OBJECT;
      1:       return 16'h0000;
      2:       return {HDR_BYTE, TRL_BYTE};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One complete frame: header, eight padding bytes, four little-endian fields, trailer.
  task automatic send_frame(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] wd, input logic [15:0] ht,
                            input logic [7:0] trailer, input bit pad_with_header);
    frames_sent++;
    send_byte(HDR_BYTE);
    for (int i = 0; i < 8; i++) send_byte(pad_with_header ? HDR_BYTE : pad_byte());
    send_byte(x[7:0]);
    send_byte(x[15:8]);
    send_byte(y[7:0]);
    send_byte(y[15:8]);
    send_byte(wd[7:0]);
    send_byte(wd[15:8]);
    send_byte(ht[7:0]);
    send_byte(ht[15:8]);
    send_byte(trailer);
  endtask

  initial begin
    int         kind;
    logic [7:0] bad_trailer;
    logic [7:0] noise;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: bytes ahead of any header are dropped, then one frame whose padding
    // is all header values (they must not restart the frame), with the sentinel in x
    // and the byte extremes in the other fields.
    burst_left = 30;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TRL_BYTE);
    send_frame(NO_OBJECT, 16'h0000, 16'h00FF, 16'hFF00, TRL_BYTE, 1'b1);

    // Random part: mostly well-formed frames with random content; the rest is line
    // noise, frames closed by a wrong trailer and frames cut short, which leave the
    // parser out of step with the following header.
    while (bytes_sent < BYTE_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        repeat ($urandom_range(1, 4)) begin
          noise = 8'($urandom_range(0, 255));
          send_byte(noise);
        end
      end else if (kind < 4) begin
        do bad_trailer = pad_byte(); while (bad_trailer == TRL_BYTE);
        send_frame(field_value(), field_value(), field_value(), field_value(),
                   bad_trailer, 1'b0);
      end else if (kind == 4) begin
        frames_sent++;
        send_byte(HDR_BYTE);
        repeat ($urandom_range(1, 16)) send_byte(pad_byte());
      end else begin
        send_frame(field_value(), field_value(), field_value(), field_value(),
                   TRL_BYTE, 1'b0);
      end
    end

    // Drain: the watchdog catches a result that never arrives.
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d frame attempts with noise, bad trailers and cut frames;",
             bytes_sent, frames_sent);
    $display("%0d box reports were checked under random sender gaps and receiver stalls.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lfobp_pkg.sv
rtl/core/lfobp_frame.sv
rtl/core/lfobp_out.sv
rtl/core/long_frame_object_box_parser.sv
sim/box_report_checker.sv
sim/tb_long_frame_object_box_parser.sv
